// File: sv/bba_pkg.sv
// ---------------------------------------------------------------------------
// Bitmap block allocator package
// Shared field widths, action/status/register codes, sequencer states and
// the result type of the word scan unit.
// ---------------------------------------------------------------------------
package bba_pkg;

    // Bitmap word geometry
    localparam int WORD_W = 32;
    localparam int POS_W  = 5;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int BIDX_W  = 12;
    localparam int CNT_W   = 13;
    localparam int RSV_W   = 12;
    localparam int STAT_W  = 2;
    localparam int DELTA_W = 14;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_BLOCK_LIMIT   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_RESERVED_LAST = 2'd1;
    localparam logic [CIDX_W-1:0] REG_FREE_BASE     = 2'd2;

    // Delta saturation bounds
    localparam logic signed [DELTA_W:0] DELTA_MIN = -15'sd8192;
    localparam logic signed [DELTA_W:0] DELTA_MAX = 15'sd8191;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_RES_FILL,
        ST_RMW_WR,
        ST_DONE
    } seq_state_t;

    // Word scan result
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } scan_res_t;

endpackage

// File: sv/bba_map_ram.sv
// ---------------------------------------------------------------------------
// Bitmap word memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module bba_map_ram
    import bba_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/bba_scan.sv
// ---------------------------------------------------------------------------
// Word scan unit
// Finds the lowest set bit of a 32-bit candidate word.
// ---------------------------------------------------------------------------
module bba_scan
    import bba_pkg::*;
(
    input  logic [WORD_W-1:0] cand,
    output scan_res_t         res
);

    logic [WORD_W-1:0] low_bit;
    logic [POS_W-1:0]  pos;

    // Isolate lowest set bit
    assign low_bit = cand & (~cand + WORD_W'(1));

    // Encode the one-hot bit
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (low_bit[i])
            begin
                pos = pos | POS_W'(i);
            end
        end
    end

    assign res.found = |cand;
    assign res.pos   = pos;

endmodule

// File: sv/bba_seq.sv
// ---------------------------------------------------------------------------
// Allocator sequencer
// Clears the map after reset, then runs allocate, free and reserve one word
// per cycle against the bitmap memory; keeps the free delta and the result.
// ---------------------------------------------------------------------------
module bba_seq
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096,
    parameter int NUM_WORDS  = 128,
    parameter int AW         = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic [CNT_W-1:0]  block_limit,
    input  logic [RSV_W-1:0]  reserved_last,
    input  logic [CNT_W-1:0]  free_count_base,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ACT_W-1:0]  action,
    input  logic [BIDX_W-1:0] req_block,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [BIDX_W-1:0] granted_block,
    output logic [CNT_W-1:0]  free_count,
    // memory
    output logic              mem_wr_en,
    output logic [AW-1:0]     mem_wr_addr,
    output logic [WORD_W-1:0] mem_wr_data,
    output logic              mem_rd_en,
    output logic [AW-1:0]     mem_rd_addr,
    input  logic [WORD_W-1:0] mem_rd_data,
    // scan unit
    output logic [WORD_W-1:0] scan_cand,
    input  scan_res_t         scan_res
);

    localparam int WCNT_W = $clog2(NUM_WORDS + 1);
    localparam int LIM_B  = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_W  = (LIM_B > CNT_W) ? LIM_B : CNT_W;
    localparam logic [LIM_W-1:0]  MAX_L     = LIM_W'(MAX_BLOCKS);
    localparam logic [LIM_W-1:0]  MAX_M1    = LIM_W'(MAX_BLOCKS - 1);
    localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(NUM_WORDS - 1);
    localparam logic [DELTA_W:0]  SAT_HI    =
        (MAX_BLOCKS > 16383) ? 15'd16383 : 15'(MAX_BLOCKS);

    seq_state_t state_reg, state_next;
    logic [WCNT_W-1:0]  word_reg, word_next;
    logic [WORD_W-1:0]  mask_reg, mask_next;
    logic               set_reg, set_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;
    logic [BIDX_W-1:0]  grant_reg, grant_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic [BIDX_W-1:0]  out_grant_reg, out_grant_next;
    logic [CNT_W-1:0]   out_cnt_reg, out_cnt_next;

    logic [LIM_W-1:0]   total_l, lim, idx_l, rsv_l, n_last;
    logic [WCNT_W-1:0]  full_words, rsv_word, word_inc, rd_word;
    logic [POS_W-1:0]   rem;
    logic [WORD_W-1:0]  valid_mask;
    logic signed [DELTA_W:0] delta_adj, delta_sum, delta_sat, cnt_sum;
    logic [DELTA_W:0]   n_rsv;

    // Search bound and reserve span from the configuration
    always_comb
    begin
        total_l    = LIM_W'(block_limit);
        lim        = (total_l < MAX_L) ? total_l : MAX_L;
        full_words = WCNT_W'(lim >> POS_W);
        rem        = lim[POS_W-1:0];
        idx_l      = LIM_W'(req_block);
        rsv_l      = LIM_W'(reserved_last);
        n_last     = (rsv_l < MAX_L) ? rsv_l : MAX_M1;
        rsv_word   = WCNT_W'(n_last >> POS_W);
        n_rsv      = (DELTA_W+1)'(n_last) + 15'd1;
        word_inc   = word_reg + WCNT_W'(1);
    end

    // Bits of the current word that lie below the search bound
    always_comb
    begin
        if (word_reg < full_words)
        begin
            valid_mask = '1;
        end
        else if (word_reg == full_words)
        begin
            valid_mask = (WORD_W'(1) << rem) - WORD_W'(1);
        end
        else
        begin
            valid_mask = '0;
        end
    end

    assign scan_cand = ~mem_rd_data & valid_mask;

    // Saturating delta update
    always_comb
    begin
        delta_sum = $signed({delta_reg[DELTA_W-1], delta_reg}) + delta_adj;
        if (delta_sum < DELTA_MIN)
        begin
            delta_sat = DELTA_MIN;
        end
        else if (delta_sum > DELTA_MAX)
        begin
            delta_sat = DELTA_MAX;
        end
        else
        begin
            delta_sat = delta_sum;
        end
    end

    // Reported free count: base plus delta, clamped
    assign cnt_sum = $signed({2'b00, free_count_base})
                   + $signed({delta_reg[DELTA_W-1], delta_reg});

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        mask_next      = mask_reg;
        set_next       = set_reg;
        stat_next      = stat_reg;
        grant_next     = grant_reg;
        delta_next     = delta_reg;
        delta_adj      = '0;
        out_valid_next = out_valid_reg & out_stall;
        out_stat_next  = out_stat_reg;
        out_grant_next = out_grant_reg;
        out_cnt_next   = out_cnt_reg;
        mem_wr_en      = 1'b0;
        mem_wr_data    = '0;
        mem_rd_en      = 1'b0;
        rd_word        = word_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en = 1'b1;
                word_next = word_inc;
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                stat_next  = STAT_OK;
                grant_next = '0;
                if (in_valid)
                begin
                    case (action)
                        ACT_ALLOC:
                        begin
                            word_next  = '0;
                            rd_word    = '0;
                            mem_rd_en  = 1'b1;
                            state_next = ST_ALLOC;
                        end
                        ACT_FREE:
                        begin
                            if (idx_l >= lim)
                            begin
                                stat_next  = STAT_RANGE;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                word_next  = WCNT_W'(req_block[BIDX_W-1:POS_W]);
                                rd_word    = WCNT_W'(req_block[BIDX_W-1:POS_W]);
                                mem_rd_en  = 1'b1;
                                mask_next  = WORD_W'(1) << req_block[POS_W-1:0];
                                set_next   = 1'b0;
                                state_next = ST_RMW_WR;
                            end
                        end
                        ACT_RESERVE:
                        begin
                            word_next  = '0;
                            state_next = ST_RES_FILL;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // One word per cycle; next word is read while this one is checked
            ST_ALLOC:
            begin
                if (scan_res.found)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = mem_rd_data | (WORD_W'(1) << scan_res.pos);
                    grant_next  = BIDX_W'({word_reg, scan_res.pos});
                    delta_adj   = -15'sd1;
                    delta_next  = DELTA_W'(delta_sat);
                    state_next  = ST_DONE;
                end
                else if (word_reg == full_words || word_reg == LAST_WORD)
                begin
                    stat_next  = STAT_NO_FREE;
                    state_next = ST_DONE;
                end
                else
                begin
                    word_next = word_inc;
                    rd_word   = word_inc;
                    mem_rd_en = 1'b1;
                end
            end

            // Whole words set directly, the last one by read-modify-write
            ST_RES_FILL:
            begin
                if (word_reg < rsv_word)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = '1;
                    word_next   = word_inc;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    mask_next  = {WORD_W{1'b1}} >> (POS_W'(WORD_W - 1) - n_last[POS_W-1:0]);
                    set_next   = 1'b1;
                    state_next = ST_RMW_WR;
                end
            end

            ST_RMW_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = set_reg ? (mem_rd_data | mask_reg)
                                      : (mem_rd_data & ~mask_reg);
                delta_adj   = set_reg ? -$signed(n_rsv) : 15'sd1;
                delta_next  = DELTA_W'(delta_sat);
                state_next  = ST_DONE;
            end

            // Hand the item to the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_grant_next = grant_reg;
                    if (cnt_sum < 0)
                    begin
                        out_cnt_next = '0;
                    end
                    else if (cnt_sum > $signed(SAT_HI))
                    begin
                        out_cnt_next = SAT_HI[CNT_W-1:0];
                    end
                    else
                    begin
                        out_cnt_next = cnt_sum[CNT_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            word_reg      <= '0;
            delta_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            delta_reg     <= delta_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mask_reg      <= mask_next;
        set_reg       <= set_next;
        stat_reg      <= stat_next;
        grant_reg     <= grant_next;
        out_stat_reg  <= out_stat_next;
        out_grant_reg <= out_grant_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign mem_wr_addr   = word_reg[AW-1:0];
    assign mem_rd_addr   = rd_word[AW-1:0];
    assign out_valid     = out_valid_reg;
    assign status        = out_stat_reg;
    assign granted_block = out_grant_reg;
    assign free_count    = out_cnt_reg;

endmodule

// File: sv/bitmap_block_allocator_top.sv
// ---------------------------------------------------------------------------
// Bitmap first-fit block allocator, top level
// From acceptance to result: allocate checks one 32-bit bitmap word per
// memory read, then hands over the result; free does a read-modify-write of
// one word; reserve sets whole words, then the last by read-modify-write; an
// out-of-range free or an unused action goes straight to the result. One item
// at a time: the next item is taken once its result is in the output register,
// which holds a waiting result without blocking the input. After reset the map
// is cleared one word per cycle (all NUM_WORDS words, 128 at the default size)
// with the input stalled; configuration resets too.
// ---------------------------------------------------------------------------
module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ACT_W-1:0]  action,
    input  logic [BIDX_W-1:0] req_block,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [BIDX_W-1:0] granted_block,
    output logic [CNT_W-1:0]  free_count
);

    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic [CNT_W-1:0]  block_limit_reg;
    logic [RSV_W-1:0]  reserved_last_reg;
    logic [CNT_W-1:0]  free_base_reg;

    logic              mem_wr_en, mem_rd_en;
    logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
    logic [WORD_W-1:0] mem_wr_data, mem_rd_data, scan_cand;
    scan_res_t         scan_res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_limit_reg   <= 13'd4096;
            reserved_last_reg <= 12'd3;
            free_base_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BLOCK_LIMIT:   block_limit_reg   <= cfg_data;
                REG_RESERVED_LAST: reserved_last_reg <= cfg_data[RSV_W-1:0];
                REG_FREE_BASE:     free_base_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    bba_map_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bba_scan u_scan (
        .cand (scan_cand),
        .res  (scan_res)
    );

    bba_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .NUM_WORDS  (NUM_WORDS),
        .AW         (AW)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .block_limit     (block_limit_reg),
        .reserved_last   (reserved_last_reg),
        .free_count_base (free_base_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .req_block       (req_block),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_block   (granted_block),
        .free_count      (free_count),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data),
        .scan_cand       (scan_cand),
        .scan_res        (scan_res)
    );

    // An accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accepting an item");

    // A failed action never grants a block
    a_no_grant_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> granted_block == '0)
        else $error("granted block set on failed action");

    // Reported count stays within the map size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(free_count) <= MAX_BLOCKS)
        else $error("free count above map size");

    // Only defined status codes are reported
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_NO_FREE
                       || status == STAT_RANGE))
        else $error("undefined status code");

endmodule

// File: tb/bitmap_block_allocator_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate, free and reserve items through the valid/stall channels
// and holds its own copy of the bitmap, the delta and the registers. Each
// returned item is checked field by field against the oldest predicted one.
// The run starts with short directed checks that take the delta to its lower
// limit, then a free run that clears the low part of the map, then randomised
// phases under several register settings, with random idling on both sides
// in phases picked at random and never in the closing phase.
// ---------------------------------------------------------------------------
module bitmap_block_allocator_top_test;
    import bba_pkg::*;

    localparam int NBLOCKS        = 4096;
    localparam int DELTA_FLOOR    = -8192;
    localparam int DELTA_CEIL     = 8191;
    localparam int BASE_TOP       = 8191;
    localparam int CYCLE_LIMIT    = 10_000_000;
    localparam int FREE_RUN_ITEMS = 256;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 230;
    localparam int TAIL_ITEMS     = 120;

    // action code with no function in the block
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BIDX_W-1:0] granted;
        logic [CNT_W-1:0]  count;
    } alloc_result_t;

    // -----------------------------------------------------------------------
    // Allocator predictor and result checker
    // -----------------------------------------------------------------------
    class alloc_scoreboard;
        bit            used_map [NBLOCKS];
        int            free_delta;
        int            block_limit;
        int            reserved_last;
        int            free_count_base;
        int            errors;
        alloc_result_t pending [$];

        function new();
            block_limit     = NBLOCKS;
            reserved_last   = 3;
            free_count_base = 0;
            free_delta      = 0;
            errors          = 0;
            foreach (used_map[i])
                used_map[i] = 1'b0;
        endfunction

        function void set_register(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_BLOCK_LIMIT:   block_limit     = int'(value);
                REG_RESERVED_LAST: reserved_last   = int'(value[RSV_W-1:0]);
                REG_FREE_BASE:     free_count_base = int'(value);
                default: ;
            endcase
        endfunction

        // saturating step of the kept delta
        function void adjust_delta(int step);
            int v;
            v = free_delta + step;
            if (v < DELTA_FLOOR)
                v = DELTA_FLOOR;
            if (v > DELTA_CEIL)
                v = DELTA_CEIL;
            free_delta = v;
        endfunction

        // work out the reply to one accepted item and queue it
        function void note_request(logic [ACT_W-1:0] act, logic [BIDX_W-1:0] idx);
            alloc_result_t r;
            int            bound;
            int            i;
            int            v;
            bit            found;
            r.status  = STAT_OK;
            r.granted = '0;
            case (act)
                ACT_ALLOC:
                begin
                    bound = (block_limit < NBLOCKS) ? block_limit : NBLOCKS;
                    found = 1'b0;
                    for (i = 0; i < bound && !found; i++)
                    begin
                        if (!used_map[i])
                        begin
                            used_map[i] = 1'b1;
                            adjust_delta(-1);
                            r.granted = BIDX_W'(i);
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        r.status = STAT_NO_FREE;
                end
                ACT_FREE:
                begin
                    if (int'(idx) >= block_limit || int'(idx) >= NBLOCKS)
                        r.status = STAT_RANGE;
                    else
                    begin
                        used_map[idx] = 1'b0;
                        adjust_delta(1);
                    end
                end
                ACT_RESERVE:
                begin
                    for (i = 0; i <= reserved_last && i < NBLOCKS; i++)
                    begin
                        used_map[i] = 1'b1;
                        adjust_delta(-1);
                    end
                end
                default: ;
            endcase
            // reported count: base plus delta, clamped to the map size
            v = free_count_base + free_delta;
            if (v < 0)
                v = 0;
            if (v > NBLOCKS)
                v = NBLOCKS;
            r.count = CNT_W'(v);
            pending.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [BIDX_W-1:0] gb,
                                   logic [CNT_W-1:0] fc);
            alloc_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected item: status %0d block %0d count %0d",
                         $time, st, gb, fc);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (gb !== want.granted)
            begin
                $display("%0t: granted_block expected %0d actual %0d",
                         $time, want.granted, gb);
                errors++;
            end
            if (fc !== want.count)
            begin
                $display("%0t: free_count expected %0d actual %0d", $time, want.count, fc);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [ACT_W-1:0]  action;
    logic [BIDX_W-1:0] req_block;
    logic              out_valid;
    logic              out_stall;
    logic [STAT_W-1:0] status;
    logic [BIDX_W-1:0] granted_block;
    logic [CNT_W-1:0]  free_count;

    alloc_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int unsigned     cycles = 0;

    bitmap_block_allocator_top #(
        .MAX_BLOCKS (NBLOCKS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .req_block     (req_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .granted_block (granted_block),
        .free_count    (free_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 6) == 0)
                stall_left = $urandom_range(1, 6);
            out_stall <= (stall_left != 0);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, granted_block, free_count);
    end

    // present one item, hold it until taken, then predict its reply
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [BIDX_W-1:0] idx);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        req_block <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(act, idx);
    endtask

    // wait for every outstanding reply, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        sb.set_register(idx, CFG_W'(value));
    endtask

    // registers for one random phase; base tracks the delta so counts move
    task automatic configure_phase();
        int pick;
        int tb;
        int rl;
        int base;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            tb = $urandom_range(1, 256);
        else if (pick < 15)
            tb = NBLOCKS;
        else if (pick < 17)
            tb = BASE_TOP;
        else
            tb = $urandom_range(0, NBLOCKS);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            rl = $urandom_range(0, 63);
        else if (pick < 8)
            rl = 0;
        else
            rl = NBLOCKS - 1;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            base = 0;
        else if (pick < 5)
            base = BASE_TOP;
        else
        begin
            base = $urandom_range(0, NBLOCKS) - sb.free_delta;
            if (base < 0)
                base = 0;
            if (base > BASE_TOP)
                base = BASE_TOP;
        end
        write_reg(REG_BLOCK_LIMIT, tb);
        write_reg(REG_RESERVED_LAST, rl);
        write_reg(REG_FREE_BASE, base);
    endtask

    // mostly allocate/free traffic, some reserves and unused codes
    task automatic send_random_item();
        int                pick;
        int                span;
        logic [BIDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        span = (sb.block_limit < NBLOCKS) ? sb.block_limit : NBLOCKS;
        idx  = BIDX_W'($urandom_range(0, NBLOCKS - 1));
        if (pick < 42)
            send_item(ACT_ALLOC, idx);
        else if (pick < 90)
        begin
            if (pick < 82 && span > 0)
                idx = BIDX_W'($urandom_range(0, span - 1));
            send_item(ACT_FREE, idx);
        end
        else if (pick < 96)
            send_item(ACT_RESERVE, idx);
        else
            send_item(ACT_UNUSED, idx);
    endtask

    // stimulus
    initial
    begin
        int n;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_BLOCK_LIMIT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = ACT_ALLOC;
        req_block = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, lowest-free search, double free, unused code
        send_item(ACT_ALLOC, 12'h000);
        send_item(ACT_ALLOC, 12'hFFF);
        send_item(ACT_FREE, 12'h000);
        send_item(ACT_ALLOC, 12'h000);
        send_item(ACT_FREE, 12'hFFF);
        send_item(ACT_UNUSED, 12'hFFF);
        send_item(ACT_RESERVE, 12'hFFF);
        send_item(ACT_ALLOC, 12'h000);
        drain();

        // empty search range, free out of range, full reserve to delta floor
        write_reg(REG_BLOCK_LIMIT, 0);
        write_reg(REG_RESERVED_LAST, NBLOCKS - 1);
        write_reg(REG_FREE_BASE, BASE_TOP);
        send_item(ACT_ALLOC, 12'h000);
        send_item(ACT_FREE, 12'h000);
        send_item(ACT_RESERVE, 12'h000);
        send_item(ACT_RESERVE, 12'h000);
        send_item(ACT_RESERVE, 12'hFFF);
        drain();

        // limit above the map size: search stops at the map end
        write_reg(REG_BLOCK_LIMIT, BASE_TOP);
        write_reg(REG_RESERVED_LAST, 0);
        write_reg(REG_FREE_BASE, NBLOCKS);
        send_item(ACT_ALLOC, 12'h000);
        send_item(ACT_FREE, 12'hFFF);
        send_item(ACT_ALLOC, 12'h000);
        send_item(ACT_FREE, 12'h000);
        send_item(ACT_RESERVE, 12'h000);
        drain();

        // one block in use
        write_reg(REG_BLOCK_LIMIT, 1);
        write_reg(REG_FREE_BASE, 0);
        send_item(ACT_FREE, 12'h001);
        send_item(ACT_FREE, 12'h000);
        send_item(ACT_ALLOC, 12'h000);
        send_item(ACT_ALLOC, 12'h000);
        drain();

        // free run: clears the low part of the map and lifts the delta
        write_reg(REG_BLOCK_LIMIT, NBLOCKS);
        for (n = 0; n < FREE_RUN_ITEMS; n++)
            send_item(ACT_FREE, BIDX_W'(n));
        repeat (16) send_item(ACT_FREE, BIDX_W'($urandom_range(0, NBLOCKS - 1)));
        drain();

        // random phases under varied settings
        for (n = 0; n < RANDOM_PHASES; n++)
        begin
            configure_phase();
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) send_random_item();
            drain();
        end

        // closing phase with no idling
        configure_phase();
        idle_on = 1'b0;
        repeat (TAIL_ITEMS) send_random_item();

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
